// ===== design/assert_macros.svh =====
// Concurrent assertion helpers. Each use expects signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dqs_pkg.sv =====
package dqs_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int ACT_W         = 3;
    localparam int DATA_W        = 32;
    localparam int STAT_W        = 2;
    localparam int POS_W         = 6;
    localparam int LEN_W         = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_SEARCH     = 3'd4,
        ACT_MIDDLE     = 3'd5
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_MID,
        S_FINISH
    } state_t;

endpackage

// ===== design/dqs_req_if.sv =====
interface dqs_req_if;
    import dqs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] operand;

    modport source (output valid, output action, output operand, input ready);
    modport sink   (input valid, input action, input operand, output ready);

endinterface

// ===== design/dqs_rsp_if.sv =====
interface dqs_rsp_if;
    import dqs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] element;
    logic [LEN_W-1:0]         length;

    modport source (output valid, output status, output position, output element,
                    output length, input ready);
    modport sink   (input valid, input status, input position, input element,
                    input length, output ready);

endinterface

// ===== design/dqs_mem.sv =====
module dqs_mem #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH)-1:0]          wr_addr,
    input  logic [dqs_pkg::DATA_W-1:0]        wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH)-1:0]          rd_addr,
    output logic [dqs_pkg::DATA_W-1:0]        rd_data
);
    import dqs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/dqs_ctrl.sv =====
module dqs_ctrl #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dqs_req_if.sink                           req,
    dqs_rsp_if.source                         rsp,
    output logic                              wr_en,
    output logic [$clog2(DEPTH)-1:0]          wr_addr,
    output logic [dqs_pkg::DATA_W-1:0]        wr_data,
    output logic                              rd_en,
    output logic [$clog2(DEPTH)-1:0]          rd_addr,
    input  logic [dqs_pkg::DATA_W-1:0]        rd_data
);
    import dqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    state_t            state_reg, state_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [DATA_W-1:0] opnd_reg, opnd_next;
    logic [AW-1:0]     front_reg, front_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    status_t           res_status_reg, res_status_next;
    logic [AW-1:0]     res_pos_reg, res_pos_next;
    logic [DATA_W-1:0] res_elem_reg, res_elem_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [DATA_W-1:0] out_elem_reg, out_elem_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;

    logic [AW-1:0]     slot_pos;
    logic [AW:0]       slot_sum;
    logic [AW-1:0]     slot_idx;
    logic [AW-1:0]     front_dec;
    logic [CW-1:0]     pos_inc;
    logic              is_full;
    logic              is_empty;
    logic              hit;
    logic              last;
    logic              out_free;
    logic              out_load;

    // The shared slot unit maps a position from the front to a ring slot.
    assign slot_sum  = {1'b0, front_reg} + {1'b0, slot_pos};
    assign slot_idx  = (slot_sum >= DEPTH_W) ? AW'(slot_sum - DEPTH_W) : AW'(slot_sum);
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign pos_inc   = CW'(pos_reg) + CW'(1);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign hit       = (rd_data == opnd_reg);
    assign last      = (pos_inc == count_reg);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign out_load  = (state_reg == S_FINISH) && out_free;

    always_comb
    begin
        slot_pos = '0;
        case (state_reg)
            S_EXEC:
            begin
                case (act_reg)
                    ACT_PUSH_BACK: slot_pos = AW'(count_reg);
                    ACT_POP_FRONT: slot_pos = AW'(1);
                    ACT_MIDDLE:    slot_pos = AW'(count_reg >> 1);
                    default:       slot_pos = '0;
                endcase
            end
            S_SCAN:  slot_pos = AW'(pos_inc);
            default: slot_pos = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (act_reg == ACT_SEARCH && !is_empty)
                begin
                    state_next = S_SCAN;
                end
                else if (act_reg == ACT_MIDDLE && !is_empty)
                begin
                    state_next = S_MID;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_MID:    state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        act_next        = act_reg;
        opnd_next       = opnd_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_elem_next   = res_elem_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_idx;
        wr_data         = opnd_reg;
        rd_en           = 1'b0;
        rd_addr         = slot_idx;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next  = req.action;
                    opnd_next = req.operand;
                end
            end
            S_EXEC:
            begin
                res_status_next = ST_OK;
                res_pos_next    = '0;
                res_elem_next   = '0;
                pos_next        = '0;
                case (act_reg)
                    ACT_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = front_dec;
                            front_next = front_dec;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ACT_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ACT_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    ACT_POP_FRONT:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            front_next = slot_idx;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    ACT_SEARCH, ACT_MIDDLE:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_pos_next = pos_reg;
                end
                else if (last)
                begin
                    res_status_next = ST_MISS;
                end
                else
                begin
                    rd_en    = 1'b1;
                    pos_next = AW'(pos_inc);
                end
            end
            S_MID:   res_elem_next = rd_data;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_elem_next   = out_elem_reg;
        out_len_next    = out_len_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_pos_next    = POS_W'(res_pos_reg);
            out_elem_next   = res_elem_reg;
            out_len_next    = LEN_W'(count_reg);
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        opnd_reg       <= opnd_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_elem_reg   <= res_elem_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_elem_reg   <= out_elem_next;
        out_len_reg    <= out_len_next;
    end

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.position = out_pos_reg;
    assign rsp.element  = out_elem_reg;
    assign rsp.length   = out_len_reg;

endmodule

// ===== design/deque_with_search_and_middle.sv =====
// Double-ended queue of signed 32-bit words held in a ring buffer of DEPTH entries.
// The req channel carries one beat per action (push front, push back, pop back,
// pop front, search, middle) with its operand. The rsp channel returns exactly one
// beat per request with status, search position, middle element and new length.
// Requests are handled one at a time: req.ready is high only while the block is idle.
// Pushes, pops and unused action codes pass from accept through S_EXEC and S_FINISH,
// where the response is loaded into the output register. Middle on a nonempty queue
// takes one memory read and passes through S_EXEC, S_MID and S_FINISH. Search reads one
// stored word per cycle through the single memory read port and compares it with
// the key until a hit or the last word, so it examines at most the current length
// of the queue, which is at most DEPTH.
// Reset clears the front pointer and the count, so the queue starts empty; the
// storage itself is not cleared and needs no clearing pass.
// The response is held in an output register. A request may be accepted while a
// response waits, but the block then holds its next result until rsp.ready
// frees that register, so a stalled receiver stops the flow after one more request.
`include "assert_macros.svh"

module deque_with_search_and_middle #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    dqs_req_if.sink   req,
    dqs_rsp_if.source rsp
);
    import dqs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    dqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dqs_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    `ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
    `ASSERT_SAME(a_full_len, rsp.valid && rsp.status == ST_FULL, rsp.length == LEN_W'(DEPTH), "full with wrong length")
    `ASSERT_SAME(a_empty_len, rsp.valid && rsp.status == ST_EMPTY, rsp.length == '0, "empty with nonzero length")
    `ASSERT_SAME(a_pos_ok, rsp.valid && rsp.position != '0, rsp.status == ST_OK, "position on failed action")

endmodule
